FILE: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the slot set table
// Field widths, request codes and the default table size.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    // Default number of value slots
    localparam int SLOTS_DEF = 16;

    // Payload field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

endpackage

`default_nettype wire

FILE: design/sst_req_if.sv
// ----------------------------------------------------------------------------
// sst_req_if: request channel of the slot set table
// Valid/ready channel carrying one insert or delete request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_req_if
    import sst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: design/sst_rsp_if.sv
// ----------------------------------------------------------------------------
// sst_rsp_if: response channel of the slot set table
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_rsp_if
    import sst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] occupancy;

    modport source (output valid, output accepted, output removed_count,
                    output occupancy, input ready);
    modport sink   (input valid, input accepted, input removed_count,
                    input occupancy, output ready);
endinterface

`default_nettype wire

FILE: design/sst_value_mem.sv
// ----------------------------------------------------------------------------
// sst_value_mem: slot value storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_value_mem
    import sst_pkg::*;
#(
    parameter int DEPTH  = SLOTS_DEF,
    parameter int ADDR_W = 4
)(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [VALUE_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/slot_set_table_top.sv
// ----------------------------------------------------------------------------
// slot_set_table_top: fixed slot set table with occupancy count
// Insert stores a value in the lowest free slot; delete frees every used
// slot holding the value and reports how many were freed.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                 handshake
//  -------  ---------  --------------------------------------  ------------
//  req      in         req_type, value                         valid/ready
//  rsp      out        accepted, removed_count, occupancy      valid/ready
//
//  One request at a time. An insert walks the used bits one slot a cycle
//  until the first free slot; when the table is full it is refused without a walk.
//  A delete streams every slot through the value memory read port, one slot
//  a cycle, and compares each slot against the value after its registered read.
//  Reset clears the used bits and the count at once; no clearing pass.
//  The result waits in an output register, and a new request is taken while
//  it waits; a finished request holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_set_table_top
    import sst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCAN_W = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [SCAN_W-1:0] LAST_SCAN = SCAN_W'(SLOTS - 1);
    localparam logic [SCAN_W-1:0] END_SCAN  = SCAN_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [VALUE_W-1:0]   key_reg, key_next;
    logic                 res_ok_reg, res_ok_next;
    logic [CNT_W-1:0]     freed_reg, freed_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [COUNT_W-1:0]   out_freed_reg, out_freed_next;
    logic [COUNT_W-1:0]   out_occ_reg, out_occ_next;

    logic                 req_fire;
    logic                 out_free;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic                 mem_rd_en;
    logic [VALUE_W-1:0]   mem_rd_data;
    logic [IDX_W-1:0]     scan_idx;
    logic [CNT_W+4:0]     freed_ext;
    logic [CNT_W+4:0]     occ_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_idx  = scan_reg[IDX_W-1:0];

    // Fit internal counts to the 5-bit result fields
    assign freed_ext = {5'b0, freed_reg};
    assign occ_ext   = {5'b0, count_reg};

    assign mem_wr_addr = scan_idx;
    assign mem_rd_en   = (state_reg == S_DEL) && (scan_reg != END_SCAN);

    sst_value_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_value_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (key_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx),
        .rd_data (mem_rd_data)
    );

    // Sequence one request: scan, read-compare-clear, then hand off result
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        key_next       = key_reg;
        res_ok_next    = res_ok_reg;
        freed_next     = freed_reg;
        out_ok_next    = out_ok_reg;
        out_freed_next = out_freed_reg;
        out_occ_next   = out_occ_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_wr_en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    key_next   = req.value;
                    scan_next  = '0;
                    freed_next = '0;
                    if (req.req_type == REQ_DELETE)
                    begin
                        res_ok_next = 1'b1;
                        state_next  = S_DEL;
                    end
                    else if (count_reg < FULL_CNT)
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_INS;
                    end
                    else
                    begin
                        res_ok_next = 1'b0;
                        state_next  = S_DONE;
                    end
                end
            end

            S_INS:
            begin
                // Take the first free slot, or refuse after the last one
                if (!used_reg[scan_idx])
                begin
                    mem_wr_en           = 1'b1;
                    used_next[scan_idx] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                    res_ok_next         = 1'b1;
                    state_next          = S_DONE;
                end
                else if (scan_reg == LAST_SCAN)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end

            S_DEL:
            begin
                // Issue the next read
                if (scan_reg != END_SCAN)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx;
                    scan_next      = scan_reg + SCAN_W'(1);
                end
                // Compare the slot read last cycle and free it on a match
                if (cmp_valid_reg)
                begin
                    if (used_reg[cmp_idx_reg] && (mem_rd_data == key_reg))
                    begin
                        used_next[cmp_idx_reg] = 1'b0;
                        count_next             = count_reg - CNT_W'(1);
                        freed_next             = freed_reg + CNT_W'(1);
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_freed_next = freed_ext[COUNT_W-1:0];
                    out_occ_next   = occ_ext[COUNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, table control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            key_reg       <= '0;
            res_ok_reg    <= 1'b0;
            freed_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_freed_reg <= '0;
            out_occ_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            key_reg       <= key_next;
            res_ok_reg    <= res_ok_next;
            freed_reg     <= freed_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_freed_reg <= out_freed_next;
            out_occ_reg   <= out_occ_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_ok_reg;
    assign rsp.removed_count = out_freed_reg;
    assign rsp.occupancy     = out_occ_reg;

endmodule

`default_nettype wire
